@@ design/uer_pkg.sv @@
// Shared constants and types for the ultrasonic echo ranger.
package uer_pkg;

    // Number of echo measurements averaged per ranging run.
    localparam int unsigned SAMPLES = 5;

    localparam int unsigned TickW  = 20;
    localparam int unsigned WidthW = 17;
    localparam int unsigned DistW  = 20;
    localparam int unsigned TrigW  = 10;
    localparam int unsigned ScaleW = 16;
    localparam int unsigned IdxW   = 4;
    localparam int unsigned RemW   = $clog2(SAMPLES + 1);
    localparam int unsigned ProdW  = WidthW + ScaleW;

    localparam logic [WidthW-1:0] WIDTH_MAX = {WidthW{1'b1}};
    localparam logic [DistW-1:0]  DIST_MAX  = {DistW{1'b1}};

    localparam logic [RemW-1:0]   SAMPLES_REM  = RemW'(SAMPLES);
    localparam logic [RemW-1:0]   REM_LAST     = RemW'(SAMPLES - 1);
    localparam logic [IdxW-1:0]   SAMPLES_IDX  = IdxW'(SAMPLES);
    // Quotient and remainder of a width of one tick.
    localparam logic [WidthW-1:0] WQ_INIT = WidthW'(1 / SAMPLES);
    localparam logic [RemW-1:0]   WR_INIT = RemW'(1 % SAMPLES);

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TRIGGER = 2'd0;
    localparam logic [1:0] REG_GAP     = 2'd1;
    localparam logic [1:0] REG_SCALE   = 2'd2;

    localparam logic [TrigW-1:0]  TRIGGER_RESET = TrigW'(20);
    localparam logic [TickW-1:0]  GAP_RESET     = TickW'(50000);
    localparam logic [ScaleW-1:0] SCALE_RESET   = ScaleW'(1114);

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_TRIG = 5'b00010,
        PH_WAIT = 5'b00100,
        PH_MEAS = 5'b01000,
        PH_GAP  = 5'b10000
    } phase_t;

endpackage

@@ design/ultrasonic_echo_ranger_core.sv @@
// Top level of the ultrasonic echo ranger: tick sequencer, averaging and scaling.
//
// Usage: every input beat on the s_ channel is one microsecond tick carrying a
// start request and the sampled echo level. Every accepted beat produces exactly
// one result beat on the m_ channel with the trigger level to drive, the busy and
// done flags, and the last stored distance in centimeters (unsigned Q8).
// A start request while idle begins a run of SAMPLES measurements: trigger pulse,
// wait for echo rise, count the echo width, then a gap. After the last gap the
// averaged width is scaled and stored, and done is high for that one beat.
// The result of a tick is registered at the edge that accepts it. Throughput is
// one tick per cycle while the receiver keeps up; the output register is the only
// stage, and its state feeds straight back into the next tick's decision.
// When the receiver stalls, the result register holds its beat and s_tready
// drops; s_tready is high whenever the result register is empty or being drained.
// The average is kept as a running quotient and remainder by SAMPLES, so the
// final step is a single multiply by scale_q16 in the done tick.
// Reset (aresetn low, synchronous) returns the block to idle with a zero distance
// and restores the register defaults. Configuration is written over APB at byte
// addresses 0, 4 and 8 (trigger_ticks, gap_ticks, scale_q16); pready is always high.
module ultrasonic_echo_ranger_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Input ticks. s_tdata: [0] start_req, [1] echo, [7:2] zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Results. m_tdata: [0] trigger, [1] busy_res, [2] done_res,
    // [22:3] distance_q8, [23] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uer_pkg::*;

    // Configuration registers.
    logic [TrigW-1:0]  trigger_ticks_reg;
    logic [TickW-1:0]  gap_ticks_reg;
    logic [ScaleW-1:0] scale_reg;

    // Sequencer state.
    phase_t             phase_reg, phase_next;
    logic [TickW-1:0]   ticks_reg, ticks_next;
    logic [WidthW-1:0]  ew_reg, ew_next;     // echo width in ticks
    logic [WidthW-1:0]  wq_reg, wq_next;     // echo width / SAMPLES
    logic [RemW-1:0]    wr_reg, wr_next;     // echo width % SAMPLES
    logic [WidthW-1:0]  sq_reg, sq_next;     // width sum / SAMPLES
    logic [RemW-1:0]    sr_reg, sr_next;     // width sum % SAMPLES
    logic [IdxW-1:0]    idx_reg, idx_next;
    logic [DistW-1:0]   dist_reg, dist_next;

    // Result register.
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    logic              cfg_write;
    logic              accept;
    logic              start_req;
    logic              echo;
    logic              trig;
    logic              done;
    logic [TickW-1:0]  tick_inc;
    logic [RemW:0]     rem_sum;
    logic              rem_carry;
    logic [WidthW-1:0] sq_fall;
    logic [RemW-1:0]   sr_fall;
    logic [WidthW-1:0] avg;
    logic [ProdW-1:0]  prod;
    logic [ProdW-9:0]  dist_raw;
    logic [DistW-1:0]  dist_sat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_ticks_reg <= TRIGGER_RESET;
            gap_ticks_reg     <= GAP_RESET;
            scale_reg         <= SCALE_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_TRIGGER: trigger_ticks_reg <= pwdata[TrigW-1:0];
                REG_GAP:     gap_ticks_reg     <= pwdata[TickW-1:0];
                REG_SCALE:   scale_reg         <= pwdata[ScaleW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TRIGGER: prdata = {{(32-TrigW){1'b0}}, trigger_ticks_reg};
            REG_GAP:     prdata = {{(32-TickW){1'b0}}, gap_ticks_reg};
            REG_SCALE:   prdata = {{(32-ScaleW){1'b0}}, scale_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // A tick is taken whenever the result register is free or draining.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign start_req = s_tdata[0];
    assign echo      = s_tdata[1];
    assign tick_inc  = ticks_reg + TickW'(1);

    // Folding the finished echo width into the running quotient and remainder.
    assign rem_sum   = {1'b0, sr_reg} + {1'b0, wr_reg};
    assign rem_carry = (rem_sum >= {1'b0, SAMPLES_REM});
    assign sr_fall   = rem_carry ? RemW'(rem_sum - {1'b0, SAMPLES_REM}) : rem_sum[RemW-1:0];
    assign sq_fall   = sq_reg + wq_reg + WidthW'(rem_carry);

    // With a zero gap the run can finish on the falling-edge tick itself.
    assign avg      = (phase_reg == PH_MEAS) ? sq_fall : sq_reg;
    assign prod     = ProdW'(avg) * ProdW'(scale_reg);
    assign dist_raw = prod[ProdW-1:8];
    assign dist_sat = (dist_raw > (ProdW-8)'(DIST_MAX)) ? DIST_MAX : dist_raw[DistW-1:0];

    always_comb begin
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        ew_next    = ew_reg;
        wq_next    = wq_reg;
        wr_next    = wr_reg;
        sq_next    = sq_reg;
        sr_next    = sr_reg;
        idx_next   = idx_reg;
        dist_next  = dist_reg;
        trig       = 1'b0;
        done       = 1'b0;

        unique case (phase_reg)
            PH_TRIG: begin
                trig       = 1'b1;
                ticks_next = tick_inc;
                if (tick_inc >= {{(TickW-TrigW){1'b0}}, trigger_ticks_reg}) begin
                    phase_next = PH_WAIT;
                    ticks_next = '0;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    ew_next    = WidthW'(1);
                    wq_next    = WQ_INIT;
                    wr_next    = WR_INIT;
                    phase_next = PH_MEAS;
                end
            end
            PH_MEAS: begin
                if (echo) begin
                    if (ew_reg < WIDTH_MAX) begin
                        ew_next = ew_reg + WidthW'(1);
                        if (wr_reg == REM_LAST) begin
                            wr_next = '0;
                            wq_next = wq_reg + WidthW'(1);
                        end else begin
                            wr_next = wr_reg + RemW'(1);
                        end
                    end
                end else begin
                    sq_next    = sq_fall;
                    sr_next    = sr_fall;
                    idx_next   = idx_reg + IdxW'(1);
                    phase_next = PH_GAP;
                    ticks_next = '0;
                    if (gap_ticks_reg == '0) begin
                        if (idx_next >= SAMPLES_IDX) begin
                            done       = 1'b1;
                            dist_next  = dist_sat;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_TRIG;
                        end
                    end
                end
            end
            PH_GAP: begin
                ticks_next = tick_inc;
                if (tick_inc >= gap_ticks_reg) begin
                    if (idx_reg >= SAMPLES_IDX) begin
                        done       = 1'b1;
                        dist_next  = dist_sat;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_TRIG;
                        ticks_next = '0;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (start_req) begin
                    phase_next = PH_TRIG;
                    ticks_next = '0;
                    ew_next    = '0;
                    wq_next    = '0;
                    wr_next    = '0;
                    sq_next    = '0;
                    sr_next    = '0;
                    idx_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            ticks_reg    <= '0;
            ew_reg       <= '0;
            wq_reg       <= '0;
            wr_reg       <= '0;
            sq_reg       <= '0;
            sr_reg       <= '0;
            idx_reg      <= '0;
            dist_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                ticks_reg <= ticks_next;
                ew_reg    <= ew_next;
                wq_reg    <= wq_next;
                wr_reg    <= wr_next;
                sq_reg    <= sq_next;
                sr_reg    <= sr_next;
                idx_reg   <= idx_next;
                dist_reg  <= dist_next;
            end
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is qualified by m_tvalid.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {1'b0, dist_next, done, (phase_next != PH_IDLE), trig};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ tb/ultrasonic_echo_ranger_core_tb.sv @@
// Self-checking testbench for the ultrasonic echo ranger core: tick stimulus, APB set-up and a predicting scoreboard.
module ultrasonic_echo_ranger_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Least number of random ticks after the directed part; an open run is finished.
    localparam int unsigned RANDOM_TICKS = 560;

    // One expected result beat, split into its fields.
    typedef struct packed {
        logic             trig;
        logic             busy;
        logic             done;
        logic [DistW-1:0] dist_q8;
    } tick_result_t;

    // Tracks the ranger's sequencing state tick by tick and holds the results it
    // predicts until the block delivers them.
    class echo_range_board;
        logic [TrigW-1:0]  trig_len;
        logic [TickW-1:0]  gap_len;
        logic [ScaleW-1:0] scale;

        phase_t            ph;
        logic [TickW-1:0]  ph_ticks;
        logic [WidthW-1:0] echo_len;
        logic [IdxW-1:0]   shot_idx;
        logic [20:0]       width_total;
        logic [DistW-1:0]  last_dist;

        tick_result_t      results_due[$];
        int unsigned       errors;

        function new();
            trig_len    = TRIGGER_RESET;
            gap_len     = GAP_RESET;
            scale       = SCALE_RESET;
            ph          = PH_IDLE;
            ph_ticks    = '0;
            echo_len    = '0;
            shot_idx    = '0;
            width_total = '0;
            last_dist   = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_TRIGGER: trig_len = value[TrigW-1:0];
                REG_GAP:     gap_len  = value[TickW-1:0];
                REG_SCALE:   scale    = value[ScaleW-1:0];
                default: ;
            endcase
        endfunction

        // End of a gap, or of a shot with a zero gap: either store the scaled average or start the next shot.
        function bit close_gap();
            logic [63:0] avg;
            logic [63:0] prod;
            if (shot_idx >= SAMPLES) begin
                avg       = width_total / SAMPLES;
                prod      = (avg * scale) >> 8;
                last_dist = (prod > DIST_MAX) ? DIST_MAX : prod[DistW-1:0];
                ph        = PH_IDLE;
                return 1'b1;
            end
            ph       = PH_TRIG;
            ph_ticks = '0;
            return 1'b0;
        endfunction

        // Advances the predicted state by one accepted tick and queues its result.
        function void note_tick(bit start, bit echo);
            tick_result_t r;
            r.trig = 1'b0;
            r.done = 1'b0;
            case (ph)
                PH_TRIG: begin
                    r.trig = 1'b1;
                    ph_ticks++;
                    if (ph_ticks >= trig_len) begin
                        ph       = PH_WAIT;
                        ph_ticks = '0;
                    end
                end
                PH_WAIT: begin
                    if (echo) begin
                        echo_len = WidthW'(1);
                        ph       = PH_MEAS;
                    end
                end
                PH_MEAS: begin
                    if (echo) begin
                        if (echo_len != WIDTH_MAX) echo_len++;
                    end else begin
                        width_total = width_total + echo_len;
                        shot_idx++;
                        ph       = PH_GAP;
                        ph_ticks = '0;
                        if (gap_len == 0) r.done = close_gap();
                    end
                end
                PH_GAP: begin
                    ph_ticks++;
                    if (ph_ticks >= gap_len) r.done = close_gap();
                end
                default: begin
                    ph = PH_IDLE;
                    if (start) begin
                        ph          = PH_TRIG;
                        ph_ticks    = '0;
                        echo_len    = '0;
                        shot_idx    = '0;
                        width_total = '0;
                    end
                end
            endcase
            r.busy    = (ph != PH_IDLE);
            r.dist_q8 = last_dist;
            results_due.push_back(r);
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_result(logic [23:0] beat);
            tick_result_t want;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t ns: result beat 0x%06h arrived with nothing expected", $time, beat);
                return;
            end
            want = results_due.pop_front();
            if (beat[0] !== want.trig) report("trigger", want.trig, beat[0]);
            if (beat[1] !== want.busy) report("busy", want.busy, beat[1]);
            if (beat[2] !== want.done) report("done", want.done, beat[2]);
            if (beat[22:3] !== want.dist_q8) report("distance", want.dist_q8, beat[22:3]);
        endfunction

        function int unsigned pending();
            return results_due.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // s_tdata: [0] start_req, [1] echo, [7:2] zero.
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata: [0] trigger, [1] busy_res, [2] done_res, [22:3] distance_q8, [23] zero.
    logic [23:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    echo_range_board sb;
    // While set, neither side idles; used for the long stretch at full rate.
    bit          calm = 1'b0;
    int unsigned quiet_cycles = 0;

    ultrasonic_echo_ranger_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // The receiver stalls about 31 times in a hundred unless the run is calm.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 31);
    end

    // Result monitor. Values read here are the ones sampled by this edge, since
    // every driver and the block itself update through nonblocking assignments.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("ultrasonic_echo_ranger_core test failed");
        $finish;
    end

    function automatic bit coin();
        return 1'($urandom_range(1));
    endfunction

    // Random bits above a register's field exercise the upper pwdata lines.
    function automatic logic [31:0] with_junk(logic [31:0] value, int unsigned w);
        if (coin()) return value | ($urandom << w);
        return value;
    endfunction

    // Sends one tick beat. s_tvalid is left high after acceptance so that
    // back-to-back beats never lower and raise it within one time step.
    task automatic send_tick(input bit start, input bit echo);
        if (!calm) begin
            while ($urandom_range(99) < 31) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, echo, start};
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(start, echo);
    endtask

    // Registers are only written once every predicted result has come back, so
    // the prediction and the block see the new value from the same tick on. A
    // ranging run may still be open; the new value then applies mid-run.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // Runs (or finishes) a ranging run with well-formed echoes: the first echo
    // lasts first_w ticks, the others rest_w. Trigger and gap ticks carry noise,
    // including start requests that must be ignored while busy.
    task automatic walk_run(input int unsigned first_w, input int unsigned rest_w);
        int unsigned held;
        int unsigned rises;
        int unsigned want;
        held  = 0;
        rises = 0;
        want  = first_w;
        if (sb.ph == PH_IDLE) send_tick(1'b1, coin());
        while (sb.ph != PH_IDLE) begin
            case (sb.ph)
                PH_WAIT: begin
                    want = (rises == 0) ? first_w : rest_w;
                    rises++;
                    held = 1;
                    send_tick(coin(), 1'b1);
                end
                PH_MEAS: begin
                    if (held < want) begin
                        held++;
                        send_tick(coin(), 1'b1);
                    end else begin
                        send_tick(coin(), 1'b0);
                    end
                end
                default: send_tick(coin(), coin());
            endcase
        end
    endtask

    // Rewrites one register, or all three, with mostly short timings so that
    // many runs fit into the random part; extremes of the scale come often.
    task automatic retune();
        int unsigned sel;
        int unsigned roll;
        logic [31:0] value;
        sel = $urandom_range(3);
        if (sel == 0 || sel == 3) begin
            roll  = $urandom_range(99);
            value = (roll < 10) ? 0 : (roll < 20) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            apb_write(REG_TRIGGER, with_junk(value, TrigW));
        end
        if (sel == 1 || sel == 3) begin
            roll  = $urandom_range(99);
            value = (roll < 15) ? 0 : (roll < 25) ? $urandom_range(10, 60) : $urandom_range(1, 6);
            apb_write(REG_GAP, with_junk(value, TickW));
        end
        if (sel == 2 || sel == 3) begin
            roll  = $urandom_range(99);
            value = (roll < 10) ? 0 : (roll < 20) ? 32'hFFFF : $urandom_range(32'hFFFF);
            apb_write(REG_SCALE, with_junk(value, ScaleW));
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned hold_pct;
        bit          st;
        bit          ec;

        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle ticks: echo and a missing start must leave the block idle.
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // A zero trigger length acts as one tick, and a zero gap ends on the
        // falling-edge tick itself. The scale keeps its reset value here.
        apb_write(REG_TRIGGER, 32'd0);
        apb_write(REG_GAP, 32'd0);
        walk_run(1, 2);

        // Longest trigger and gap, each cut short mid-phase: the counters are
        // already past the new limits, so each phase ends on the next tick.
        apb_write(REG_SCALE, 32'hFFFF);
        apb_write(REG_TRIGGER, 32'd1023);
        apb_write(REG_GAP, 32'hFFFFF);
        send_tick(1'b1, 1'b0);
        repeat (6) send_tick(1'b0, 1'b1);
        apb_write(REG_TRIGGER, 32'd2);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        repeat (3) send_tick(coin(), coin());
        apb_write(REG_GAP, 32'd1);
        send_tick(1'b0, 1'b0);
        apb_write(REG_GAP, 32'd0);
        apb_write(REG_TRIGGER, 32'd1);
        walk_run(3, 1);

        // One run with long echoes at full scale and no idling on either side;
        // this is the long stretch at full rate.
        calm = 1'b1;
        walk_run(60, 40);
        calm = 1'b0;

        // Random part: mostly well-formed runs with random echo widths, noise on
        // the idle, trigger and gap ticks, and occasional register changes, some
        // of them in the middle of a run.
        sent     = 0;
        hold_pct = 85;
        while (sent < RANDOM_TICKS || sb.ph != PH_IDLE) begin
            if ($urandom_range(199) == 0) retune();
            st = coin();
            ec = coin();
            case (sb.ph)
                PH_IDLE: begin
                    if ($urandom_range(9) == 0) retune();
                    st = ($urandom_range(99) < 40);
                    if (st) hold_pct = ($urandom_range(99) < 15) ? 98 : 85;
                end
                PH_WAIT: ec = ($urandom_range(99) < 35);
                PH_MEAS: ec = ($urandom_range(99) < hold_pct);
                default: ;
            endcase
            send_tick(st, ec);
            sent++;
        end

        // Drain: wait for every predicted beat, then a few cycles more so that a
        // stray extra beat would still be seen.
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ultrasonic_echo_ranger_core test passed");
        end else begin
            $display("ultrasonic_echo_ranger_core test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/uer_pkg.sv
design/ultrasonic_echo_ranger_core.sv
tb/ultrasonic_echo_ranger_core_tb.sv
